FILE: src/brs_pkg.sv
package brs_pkg;

  // Default geometry and weight precision.
  localparam int unsigned MAX_WIDTH_DEF        = 256;
  localparam int unsigned MAX_HEIGHT_DEF       = 256;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 14;

  // Fixed field widths.
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PIXEL_W  = 3 * CHAN_W;
  localparam int unsigned REG_W    = 9;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned POS_W    = COORD_W + SCALE_W;
  localparam int unsigned INT_W    = POS_W - FRAC_W;
  localparam int unsigned TAP_W    = INT_W + 2;
  localparam int unsigned DIST_W   = FRAC_W + 2;
  localparam int unsigned CMP_W    = COORD_W + 1;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 2'd2;

  typedef enum logic {
    ITEM_LOAD    = 1'b0,
    ITEM_REQUEST = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e                kind;
    logic [COORD_W-1:0]        column;
    logic [COORD_W-1:0]        row;
    logic [PIXEL_W-1:0]        pixel;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] tag;
  } krn_ctl_t;

endpackage

FILE: src/brs_front.sv
module brs_front #(
  parameter int unsigned MAX_WIDTH  = brs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = brs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [brs_pkg::COORD_W-1:0]  column_i,
  input  logic [brs_pkg::COORD_W-1:0]  row_i,
  input  logic [brs_pkg::CHAN_W-1:0]   red_in_i,
  input  logic [brs_pkg::CHAN_W-1:0]   green_in_i,
  input  logic [brs_pkg::CHAN_W-1:0]   blue_in_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output brs_pkg::item_t               item_o
);

  brs_pkg::item_t                     queue_q [brs_pkg::QUEUE_DEPTH];
  logic [brs_pkg::QPTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [brs_pkg::QCNT_W-1:0]         count_q;
  logic                               keep, push, pop;
  brs_pkg::item_t                     item_new;

  // Loads that fall outside the frame store are dropped here.
  always_comb begin
    item_new.kind   = brs_pkg::item_kind_e'(cmd_i);
    item_new.column = column_i;
    item_new.row    = row_i;
    item_new.pixel  = {red_in_i, green_in_i, blue_in_i};
    keep = (item_new.kind == brs_pkg::ITEM_REQUEST) ||
           (({1'b0, column_i} < brs_pkg::CMP_W'(MAX_WIDTH)) &&
            ({1'b0, row_i} < brs_pkg::CMP_W'(MAX_HEIGHT)));
  end

  assign in_ready_o   = (count_q != brs_pkg::QCNT_W'(brs_pkg::QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o && keep;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + brs_pkg::QCNT_W'(push) - brs_pkg::QCNT_W'(pop);
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> count_q < brs_pkg::QCNT_W'(brs_pkg::QUEUE_DEPTH))
    else $error("queue written while full");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

FILE: src/brs_kernel.sv
module brs_kernel #(
  parameter int unsigned WEIGHT_FRAC_BITS = brs_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brs_pkg::krn_ctl_t             req_i,
  input  logic [brs_pkg::DIST_W-1:0]    dist_i,
  output brs_pkg::krn_ctl_t             rsp_o,
  output logic signed [WEIGHT_FRAC_BITS+1:0] weight_o
);

  localparam int unsigned WTW   = WEIGHT_FRAC_BITS + 2;
  localparam int unsigned SH    = 48 - WEIGHT_FRAC_BITS;
  localparam int unsigned SQ_W  = 2 * brs_pkg::DIST_W - 1;
  localparam int unsigned CU_W  = 3 * brs_pkg::DIST_W - 2;
  localparam int unsigned V_W   = 56;

  brs_pkg::krn_ctl_t          ctl1_q, ctl2_q, ctl3_q;
  logic [brs_pkg::DIST_W-1:0] t1_q, t2_q;
  logic [SQ_W-1:0]            sq1_q, sq2_q;
  logic [CU_W-1:0]            cu2_q;
  logic signed [V_W-1:0]      te, sqe, cue, v, vr;
  logic signed [WTW-1:0]      w3_q;

  always_ff @(posedge clk_i) begin
    t1_q  <= dist_i;
    sq1_q <= SQ_W'(dist_i * dist_i);
    t2_q  <= t1_q;
    sq2_q <= sq1_q;
    cu2_q <= CU_W'(sq1_q * t1_q);
    w3_q  <= vr[WTW-1:0];
  end

  // Cubic convolution kernel with a = -1, exact in Q.48, then rounded half up.
  always_comb begin
    te  = signed'(V_W'(t2_q));
    sqe = signed'(V_W'(sq2_q));
    cue = signed'(V_W'(cu2_q));
    if (t2_q <= brs_pkg::DIST_W'(32'h10000)) begin
      v = (V_W'(1) <<< 48) - (sqe <<< 17) + cue;
    end else if (t2_q <= brs_pkg::DIST_W'(32'h20000)) begin
      v = (V_W'(1) <<< 50) - (te <<< 35) + (sqe <<< 18) + (sqe <<< 16) - cue;
    end else begin
      v = '0;
    end
    vr = (v + (V_W'(1) <<< (SH - 1))) >>> SH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= req_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  assign rsp_o    = ctl3_q;
  assign weight_o = w3_q;

endmodule

FILE: src/brs_back.sv
module brs_back #(
  parameter int unsigned MAX_WIDTH        = brs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT       = brs_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = brs_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     item_valid_i,
  output logic                                     item_ready_o,
  input  brs_pkg::item_t                           item_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]           src_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]          src_h_i,
  input  logic [brs_pkg::SCALE_W-1:0]              scale_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [brs_pkg::COORD_W-1:0]              out_column_o,
  output logic [brs_pkg::COORD_W-1:0]              out_row_o,
  output logic [brs_pkg::CHAN_W-1:0]               red_out_o,
  output logic [brs_pkg::CHAN_W-1:0]               green_out_o,
  output logic [brs_pkg::CHAN_W-1:0]               blue_out_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WTW   = WEIGHT_FRAC_BITS + 2;
  localparam int unsigned PW    = 2 * WTW;
  localparam int unsigned PRW   = PW + 9;
  localparam int unsigned ACW   = PRW + 4;
  localparam int unsigned RSH   = 2 * WEIGHT_FRAC_BITS;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MULT  = 6'b000010,
    ST_WGT   = 6'b000100,
    ST_TAPS  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [brs_pkg::PIXEL_W-1:0]     mem [DEPTH];
  logic [brs_pkg::PIXEL_W-1:0]     rd_q;
  logic [brs_pkg::COORD_W-1:0]     col_q, row_q;
  logic [brs_pkg::POS_W-1:0]       px_q, py_q;
  logic [2:0]                      feed_q;
  logic                            feed_on_q;
  logic [3:0]                      tap_q;
  logic                            v1_q;
  logic signed [WTW-1:0]           wx_q [4];
  logic signed [WTW-1:0]           wy_q [4];
  logic signed [PW-1:0]            wt_q;
  logic signed [ACW-1:0]           acc_r_q, acc_g_q, acc_b_q;
  logic                            out_valid_q;
  logic [brs_pkg::COORD_W-1:0]     oc_q, or_q;
  logic [brs_pkg::CHAN_W-1:0]      ored_q, ogrn_q, oblu_q;

  brs_pkg::krn_ctl_t               krn_req, krn_rsp;
  logic [brs_pkg::DIST_W-1:0]      tap_dist;
  logic signed [WTW-1:0]           krn_w;
  logic [brs_pkg::FRAC_W-1:0]      frac;

  logic signed [brs_pkg::TAP_W-1:0] sx, sy, sx_c, sy_c;
  logic [AW-1:0]                   tap_addr, load_addr, mem_addr;
  logic                            mem_we, mem_re, pop, out_load;
  logic signed [PRW-1:0]           pr_r, pr_g, pr_b;

  function automatic logic [brs_pkg::CHAN_W-1:0] finish(input logic signed [ACW-1:0] s);
    logic signed [ACW-1:0] r;
    r = (s + (ACW'(1) <<< (RSH - 1))) >>> RSH;
    if (s < 0) return '0;
    if (r > ACW'(255)) return '1;
    return r[brs_pkg::CHAN_W-1:0];
  endfunction

  // Weight requests: distances 1+f, f, 1-f, 2-f for x, then for y.
  always_comb begin
    frac = feed_q[2] ? py_q[brs_pkg::FRAC_W-1:0] : px_q[brs_pkg::FRAC_W-1:0];
    unique case (feed_q[1:0])
      2'd0:    tap_dist = brs_pkg::DIST_W'(32'h10000) + brs_pkg::DIST_W'(frac);
      2'd1:    tap_dist = brs_pkg::DIST_W'(frac);
      2'd2:    tap_dist = brs_pkg::DIST_W'(32'h10000) - brs_pkg::DIST_W'(frac);
      default: tap_dist = brs_pkg::DIST_W'(32'h20000) - brs_pkg::DIST_W'(frac);
    endcase
    krn_req.valid = feed_on_q;
    krn_req.tag   = feed_q;
  end

  brs_kernel #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_kernel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (krn_req),
    .dist_i   (tap_dist),
    .rsp_o    (krn_rsp),
    .weight_o (krn_w)
  );

  // Tap addressing with clamp to the image edge.
  always_comb begin
    sx = signed'(brs_pkg::TAP_W'(px_q[brs_pkg::POS_W-1:brs_pkg::FRAC_W]))
         + brs_pkg::TAP_W'(tap_q[1:0]) - brs_pkg::TAP_W'(1);
    sy = signed'(brs_pkg::TAP_W'(py_q[brs_pkg::POS_W-1:brs_pkg::FRAC_W]))
         + brs_pkg::TAP_W'(tap_q[3:2]) - brs_pkg::TAP_W'(1);
    if (sx < 0)                                     sx_c = '0;
    else if (sx >= signed'(brs_pkg::TAP_W'(src_w_i))) sx_c = brs_pkg::TAP_W'(src_w_i) - 1'b1;
    else                                            sx_c = sx;
    if (sy < 0)                                     sy_c = '0;
    else if (sy >= signed'(brs_pkg::TAP_W'(src_h_i))) sy_c = brs_pkg::TAP_W'(src_h_i) - 1'b1;
    else                                            sy_c = sy;
    tap_addr  = AW'(sy_c) * AW'(MAX_WIDTH) + AW'(sx_c);
    load_addr = AW'(item_i.row) * AW'(MAX_WIDTH) + AW'(item_i.column);
  end

  assign item_ready_o = (state_q == ST_IDLE);
  assign pop          = item_valid_i && item_ready_o;
  assign mem_we       = pop && (item_i.kind == brs_pkg::ITEM_LOAD);
  assign mem_re       = (state_q == ST_TAPS);
  assign mem_addr     = mem_we ? load_addr : tap_addr;
  assign out_load     = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= item_i.pixel;
    end else if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pop && item_i.kind == brs_pkg::ITEM_REQUEST) state_d = ST_MULT;
      ST_MULT:  state_d = ST_WGT;
      ST_WGT:   if (krn_rsp.valid && krn_rsp.tag == 3'd7) state_d = ST_TAPS;
      ST_TAPS:  if (tap_q == 4'd15) state_d = ST_DRAIN;
      ST_DRAIN: if (!v1_q) state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pr_r = signed'({1'b0, rd_q[23:16]}) * wt_q;
    pr_g = signed'({1'b0, rd_q[15:8]})  * wt_q;
    pr_b = signed'({1'b0, rd_q[7:0]})   * wt_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      col_q <= item_i.column;
      row_q <= item_i.row;
    end
    if (state_q == ST_MULT) begin
      px_q <= brs_pkg::POS_W'(col_q * scale_i);
      py_q <= brs_pkg::POS_W'(row_q * scale_i);
    end
    if (krn_rsp.valid) begin
      if (krn_rsp.tag[2]) wy_q[krn_rsp.tag[1:0]] <= krn_w;
      else                wx_q[krn_rsp.tag[1:0]] <= krn_w;
    end
    if (state_q == ST_TAPS) begin
      wt_q <= PW'(wx_q[tap_q[1:0]] * wy_q[tap_q[3:2]]);
    end
    if (state_q == ST_WGT) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end else if (v1_q) begin
      acc_r_q <= acc_r_q + ACW'(pr_r);
      acc_g_q <= acc_g_q + ACW'(pr_g);
      acc_b_q <= acc_b_q + ACW'(pr_b);
    end
    if (out_load) begin
      oc_q   <= col_q;
      or_q   <= row_q;
      ored_q <= finish(acc_r_q);
      ogrn_q <= finish(acc_g_q);
      oblu_q <= finish(acc_b_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      feed_q      <= '0;
      feed_on_q   <= 1'b0;
      tap_q       <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MULT) begin
        feed_on_q <= 1'b1;
        feed_q    <= '0;
      end else if (feed_on_q) begin
        feed_q <= feed_q + 1'b1;
        if (feed_q == 3'd7) feed_on_q <= 1'b0;
      end
      v1_q <= (state_q == ST_TAPS);
      if (state_q == ST_TAPS) tap_q <= tap_q + 1'b1;
      else                    tap_q <= '0;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_column_o = oc_q;
  assign out_row_o    = or_q;
  assign red_out_o    = ored_q;
  assign green_out_o  = ogrn_q;
  assign blue_out_o   = oblu_q;

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE)
    else $error("frame store written outside idle");
  a_tap_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (state_q == ST_TAPS || state_q == ST_DRAIN))
    else $error("tap product outside tap window");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised without finishing a request");

endmodule

FILE: src/bicubic_image_resampler.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    cmd_i column_i row_i red_in_i green_in_i blue_in_i
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i cfg_data_i
// out       output     out_valid_o / out_ready_i  out_column_o out_row_o red_out_o green_out_o
//                                                 blue_out_o
//
// A load is written to the frame store as it leaves the queue. A request holds the
// back end from the step that takes it from the queue through the coordinate
// multiply, eight weights run through the three-stage kernel unit, sixteen taps read
// through the single frame store port, a drain step and a finish step.
// Reset clears control state and sets the registers to their defaults; the frame
// store is not cleared. A stalled output holds the back end in its finish step while
// the queue still takes items until it is full.
module bicubic_image_resampler #(
  parameter int unsigned MAX_WIDTH        = brs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT       = brs_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = brs_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [brs_pkg::COORD_W-1:0]    column_i,
  input  logic [brs_pkg::COORD_W-1:0]    row_i,
  input  logic [brs_pkg::CHAN_W-1:0]     red_in_i,
  input  logic [brs_pkg::CHAN_W-1:0]     green_in_i,
  input  logic [brs_pkg::CHAN_W-1:0]     blue_in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [brs_pkg::SCALE_W-1:0]    cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [brs_pkg::COORD_W-1:0]    out_column_o,
  output logic [brs_pkg::COORD_W-1:0]    out_row_o,
  output logic [brs_pkg::CHAN_W-1:0]     red_out_o,
  output logic [brs_pkg::CHAN_W-1:0]     green_out_o,
  output logic [brs_pkg::CHAN_W-1:0]     blue_out_o
);

  localparam int unsigned WDW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HDW = $clog2(MAX_HEIGHT + 1);

  // The width and height are kept already clamped to 1..MAX, so the tap
  // addressing sees the effective image size directly.
  logic [WDW-1:0]                  src_w_q;
  logic [HDW-1:0]                  src_h_q;
  logic [brs_pkg::SCALE_W-1:0]     scale_q;
  logic [brs_pkg::CMP_W-1:0]       cfg_val;
  logic                            cfg_xfer;
  logic                            item_valid, item_ready;
  brs_pkg::item_t                  item;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign cfg_val     = brs_pkg::CMP_W'(cfg_data_i[brs_pkg::REG_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= WDW'(MAX_WIDTH < 256 ? MAX_WIDTH : 256);
      src_h_q <= HDW'(MAX_HEIGHT < 256 ? MAX_HEIGHT : 256);
      scale_q <= brs_pkg::SCALE_W'(32'h10000);
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        brs_pkg::CFG_SRC_WIDTH: begin
          if (cfg_val == '0)                              src_w_q <= WDW'(1);
          else if (cfg_val > brs_pkg::CMP_W'(MAX_WIDTH))  src_w_q <= WDW'(MAX_WIDTH);
          else                                            src_w_q <= WDW'(cfg_val);
        end
        brs_pkg::CFG_SRC_HEIGHT: begin
          if (cfg_val == '0)                              src_h_q <= HDW'(1);
          else if (cfg_val > brs_pkg::CMP_W'(MAX_HEIGHT)) src_h_q <= HDW'(MAX_HEIGHT);
          else                                            src_h_q <= HDW'(cfg_val);
        end
        brs_pkg::CFG_INV_SCALE: scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: takes every transfer, drops loads outside the store, queues the rest.
  brs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // Back end: frame store, weight unit, tap sequencer and output register.
  brs_back #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_HEIGHT       (MAX_HEIGHT),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .src_w_i      (src_w_q),
    .src_h_i      (src_h_q),
    .scale_i      (scale_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o)
  );

endmodule
